// ----- sv/i2c_master_byte_engine_core_macros.svh -----
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define MBE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/i2c_mbe_pkg.sv -----
`timescale 1ns / 1ps

package i2c_mbe_pkg;

	// command codes on the input stream
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_TICKS_PER_US   = 2'd0;
	localparam logic [1:0] CFG_ACK_POLL_LIMIT = 2'd1;

	localparam int TPU_W       = 13;
	localparam int STREAM_W    = 16;
	localparam int CFG_INDEX_W = 2;

	// request queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} req_t;

endpackage

// ----- sv/i2c_mbe_front.sv -----
`timescale 1ns / 1ps

module i2c_mbe_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [i2c_mbe_pkg::STREAM_W-1:0] s_tdata,
	output logic                           q_valid,
	output i2c_mbe_pkg::req_t              q_req,
	input  logic                           q_pop
);
	import i2c_mbe_pkg::*;

	req_t              fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	req_t              dec;
	logic              push;

	// unknown command codes are classified as no command
	always_comb begin
		dec.tx_byte  = s_tdata[10:3];
		dec.send_ack = s_tdata[11];
		dec.sda_in   = s_tdata[12];
		case (s_tdata[2:0])
			CMD_START: dec.op = CMD_START;
			CMD_STOP:  dec.op = CMD_STOP;
			CMD_WRITE: dec.op = CMD_WRITE;
			CMD_READ:  dec.op = CMD_READ;
			default:   dec.op = CMD_NONE;
		endcase
	end

	assign s_tready = (count_q != QCNT_W'(QDEPTH));
	assign push     = s_tvalid & s_tready;
	assign q_valid  = (count_q != '0);
	assign q_req    = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/i2c_mbe_back.sv -----
`timescale 1ns / 1ps

module i2c_mbe_back #(
	parameter int DELAY_COUNTER_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  i2c_mbe_pkg::req_t                 q_req,
	output logic                              q_pop,
	input  logic                              cfg_valid,
	input  logic [i2c_mbe_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [i2c_mbe_pkg::TPU_W-1:0]     cfg_data,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [i2c_mbe_pkg::STREAM_W-1:0]  m_tdata
);
	import i2c_mbe_pkg::*;

	localparam int DW = DELAY_COUNTER_WIDTH;
	localparam int PW = TPU_W + 2;
	localparam int MW = (DW > PW) ? DW : PW;

	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_ST_A = 4'd1;
	localparam logic [3:0] PH_ST_B = 4'd2;
	localparam logic [3:0] PH_SP_A = 4'd3;
	localparam logic [3:0] PH_SP_B = 4'd4;
	localparam logic [3:0] PH_WR_A = 4'd5;
	localparam logic [3:0] PH_WR_B = 4'd6;
	localparam logic [3:0] PH_WR_C = 4'd7;
	localparam logic [3:0] PH_WA_A = 4'd8;
	localparam logic [3:0] PH_WA_B = 4'd9;
	localparam logic [3:0] PH_RD_A = 4'd10;
	localparam logic [3:0] PH_RD_B = 4'd11;
	localparam logic [3:0] PH_AK_A = 4'd12;
	localparam logic [3:0] PH_AK_B = 4'd13;
	localparam logic [3:0] PH_AK_C = 4'd14;

	function automatic logic [DW-1:0] sat_delay(input logic [PW-1:0] p);
		logic [MW-1:0] pe;
		logic [MW-1:0] lim;
		pe  = MW'(p);
		lim = MW'({DW{1'b1}});
		if (pe > lim) begin
			pe = lim;
		end
		return pe[DW-1:0];
	endfunction

	logic [TPU_W-1:0] tpu_q;
	logic [7:0]       limit_q;

	logic [3:0]    phase_q;
	logic [2:0]    bit_q;
	logic [7:0]    shift_q;
	logic [DW-1:0] delay_q;
	logic [7:0]    poll_q;
	logic          scl_q;
	logic          sda_q;
	logic [7:0]    rx_q;
	logic          nack_q;
	logic          ack_choice_q;

	logic [3:0]    phase_d;
	logic [2:0]    bit_d;
	logic [7:0]    shift_d;
	logic [DW-1:0] delay_d;
	logic [7:0]    poll_d;
	logic          scl_d;
	logic          sda_d;
	logic [7:0]    rx_d;
	logic          nack_d;
	logic          ack_choice_d;
	logic          done_d;

	logic [DW-1:0] d1;
	logic [DW-1:0] d2;
	logic [DW-1:0] d4;
	logic [7:0]    poll_inc;

	logic                m_tvalid_q;
	logic [STREAM_W-1:0] m_tdata_q;

	assign d1 = sat_delay({2'b00, tpu_q});
	assign d2 = sat_delay({1'b0, tpu_q, 1'b0});
	assign d4 = sat_delay({tpu_q, 2'b00});
	assign poll_inc = (poll_q != 8'hFF) ? (poll_q + 8'd1) : poll_q;

	assign q_pop = q_valid & (~m_tvalid_q | m_tready);

	always_comb begin
		phase_d      = phase_q;
		bit_d        = bit_q;
		shift_d      = shift_q;
		delay_d      = delay_q;
		poll_d       = poll_q;
		scl_d        = scl_q;
		sda_d        = sda_q;
		rx_d         = rx_q;
		nack_d       = nack_q;
		ack_choice_d = ack_choice_q;
		done_d       = 1'b0;
		if (phase_q == PH_IDLE) begin
			case (q_req.op)
				CMD_START: begin
					sda_d   = 1'b1;
					scl_d   = 1'b1;
					delay_d = d4;
					phase_d = PH_ST_A;
				end
				CMD_STOP: begin
					scl_d   = 1'b1;
					sda_d   = 1'b0;
					delay_d = d4;
					phase_d = PH_SP_A;
				end
				CMD_WRITE: begin
					nack_d  = 1'b0;
					bit_d   = 3'd0;
					sda_d   = q_req.tx_byte[7];
					shift_d = {q_req.tx_byte[6:0], 1'b0};
					delay_d = d2;
					phase_d = PH_WR_A;
				end
				CMD_READ: begin
					ack_choice_d = q_req.send_ack;
					shift_d      = 8'd0;
					bit_d        = 3'd0;
					sda_d        = 1'b1;
					scl_d        = 1'b1;
					delay_d      = d2;
					phase_d      = PH_RD_A;
				end
				default: ;
			endcase
		end else if (delay_q > DW'(1)) begin
			delay_d = delay_q - DW'(1);
		end else begin
			case (phase_q)
				PH_ST_A: begin
					sda_d   = 1'b0;
					delay_d = d4;
					phase_d = PH_ST_B;
				end
				PH_ST_B: begin
					scl_d   = 1'b0;
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				PH_SP_A: begin
					sda_d   = 1'b1;
					delay_d = d4;
					phase_d = PH_SP_B;
				end
				PH_SP_B: begin
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				PH_WR_A: begin
					scl_d   = 1'b1;
					delay_d = d2;
					phase_d = PH_WR_B;
				end
				PH_WR_B: begin
					scl_d   = 1'b0;
					delay_d = d2;
					phase_d = PH_WR_C;
				end
				PH_WR_C: begin
					if (bit_q == 3'd7) begin
						sda_d   = 1'b1;
						delay_d = d1;
						phase_d = PH_WA_A;
					end else begin
						bit_d   = bit_q + 3'd1;
						sda_d   = shift_q[7];
						shift_d = {shift_q[6:0], 1'b0};
						delay_d = d2;
						phase_d = PH_WR_A;
					end
				end
				PH_WA_A: begin
					scl_d   = 1'b1;
					poll_d  = 8'd0;
					delay_d = d1;
					phase_d = PH_WA_B;
				end
				PH_WA_B: begin
					delay_d = '0;
					if (!q_req.sda_in) begin
						scl_d   = 1'b0;
						nack_d  = 1'b0;
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end else begin
						poll_d = poll_inc;
						if (poll_inc > limit_q) begin
							nack_d  = 1'b1;
							scl_d   = 1'b1;
							sda_d   = 1'b0;
							delay_d = d4;
							phase_d = PH_SP_A;
						end
					end
				end
				PH_RD_A: begin
					shift_d = {shift_q[6:0], q_req.sda_in};
					scl_d   = 1'b0;
					delay_d = d1;
					phase_d = PH_RD_B;
				end
				PH_RD_B: begin
					if (bit_q != 3'd7) begin
						bit_d   = bit_q + 3'd1;
						scl_d   = 1'b1;
						delay_d = d2;
						phase_d = PH_RD_A;
					end else begin
						rx_d    = shift_q;
						sda_d   = ~ack_choice_q;
						delay_d = d2;
						phase_d = PH_AK_A;
					end
				end
				PH_AK_A: begin
					scl_d   = 1'b1;
					delay_d = d2;
					phase_d = PH_AK_B;
				end
				PH_AK_B: begin
					scl_d   = 1'b0;
					delay_d = d2;
					phase_d = PH_AK_C;
				end
				PH_AK_C: begin
					if (ack_choice_q) begin
						sda_d = 1'b1;
					end
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q   <= TPU_W'(1);
			limit_q <= 8'd250;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TICKS_PER_US:   tpu_q   <= cfg_data;
				CFG_ACK_POLL_LIMIT: limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_q        <= '0;
			shift_q      <= '0;
			delay_q      <= '0;
			poll_q       <= '0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			rx_q         <= '0;
			nack_q       <= 1'b0;
			ack_choice_q <= 1'b0;
		end else if (q_pop) begin
			phase_q      <= phase_d;
			bit_q        <= bit_d;
			shift_q      <= shift_d;
			delay_q      <= delay_d;
			poll_q       <= poll_d;
			scl_q        <= scl_d;
			sda_q        <= sda_d;
			rx_q         <= rx_d;
			nack_q       <= nack_d;
			ack_choice_q <= ack_choice_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (q_pop) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			m_tdata_q <= {3'b000, nack_d, rx_d, done_d, (phase_d != PH_IDLE), sda_d, scl_d};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- sv/i2c_master_byte_engine_core.sv -----
// i2c master byte engine: one input request is one tick of the bus timer
// s_* channel: request per tick with an optional command (start, stop,
//   write byte, read byte) and the sampled sda level; codes 5 to 7 do nothing
// m_* channel: one result per request with the scl/sda drive levels, busy,
//   done pulse, last received byte and the ack error flag
// cfg_* channel: index 0 ticks_per_us, index 1 ack_poll_limit; always ready,
//   write only while no request is in flight
// a request passes the request queue and then one engine step into the
//   output register before its result can be taken
// throughput: 1 request per cycle while m_tready keeps the output register free
// bus waits of 1, 2 and 4 us run as many requests as n * ticks_per_us,
//   saturated to the delay counter width, and at least one request
// reset: bus released (scl and sda high), engine idle, queue and output empty,
//   ticks_per_us back to 1 and ack_poll_limit to 250
// receiver stall: the result waits in the output register, the 2-entry queue
//   keeps taking requests until full, then s_tready drops; nothing is lost
`timescale 1ns / 1ps

module i2c_master_byte_engine_core #(
	parameter int DELAY_COUNTER_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [2:0] command, [10:3] tx_byte, [11] send_ack, [12] sda_in, [15:13] zero
	input  logic [i2c_mbe_pkg::STREAM_W-1:0]  s_tdata,
	// result channel
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte,
	// [12] ack_error, [15:13] zero
	output logic [i2c_mbe_pkg::STREAM_W-1:0]  m_tdata,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [i2c_mbe_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [i2c_mbe_pkg::TPU_W-1:0]     cfg_data
);
	import i2c_mbe_pkg::*;

	logic q_valid;
	logic q_pop;
	req_t q_req;

	// config registers take a write in any cycle
	assign cfg_ready = 1'b1;

	// front: decode the command and queue the request
	i2c_mbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop)
	);

	// back: bus sequencer, one step per popped request, output register
	i2c_mbe_back #(
		.DELAY_COUNTER_WIDTH (DELAY_COUNTER_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- sv/i2c_mbe_checker.sv -----
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_core_macros.svh"

module i2c_mbe_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [i2c_mbe_pkg::STREAM_W-1:0] m_tdata
);

	// a stalled result holds
	`MBE_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

	// a completing tick is never busy
	`MBE_ASSERT_NOW(a_done_not_busy, clk, arst_n, m_tvalid, !(m_tdata[3] && m_tdata[2]), "done with busy set")

	// two completions cannot follow back to back
	`MBE_ASSERT_NEXT(a_done_spaced, clk, arst_n, m_tvalid && m_tready && m_tdata[3], !(m_tvalid && m_tdata[3]), "done on consecutive results")

	// with the output empty the queue cannot be full
	`MBE_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready, "input blocked with output empty")

endmodule

bind i2c_master_byte_engine_core i2c_mbe_checker u_checker (.*);

// ----- tb/tb_i2c_master_byte_engine_core.sv -----
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine_core;
	import i2c_mbe_pkg::*;

	localparam int          DLY_W        = 16;
	localparam int          DRAIN_CYCLES = 4;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int          ERR_PRINT    = 40;
	localparam int          PHASE_TICKS  = 60;
	localparam int          N_SETS       = 6;

	// codes the engine ignores
	localparam logic [2:0] CMD_BAD_LO = 3'd5;
	localparam logic [2:0] CMD_BAD_HI = 3'd7;

	// sda source while the engine is not polling for an ack
	localparam int SDA_LOW  = 0;
	localparam int SDA_HIGH = 1;
	localparam int SDA_RAND = 2;

	typedef enum logic [3:0] {
		ENG_IDLE, START_HOLD, START_LOW, STOP_HOLD, STOP_RELEASE,
		WR_SETUP, WR_HIGH, WR_LOW, ACK_SETUP, ACK_POLL,
		RD_HIGH, RD_LOW, MACK_SETUP, MACK_HIGH, MACK_LOW
	} eng_phase_e;

	// same layout as m_tdata[12:0]
	typedef struct packed {
		logic       err;
		logic [7:0] rx;
		logic       done;
		logic       busy;
		logic       sda;
		logic       scl;
	} bus_levels_t;

	class i2c_engine_shadow;
		eng_phase_e     ph;
		logic [2:0]     bit_idx;
		logic [7:0]     shifter;
		int unsigned    dly;
		logic [7:0]     polls;
		logic           scl;
		logic           sda;
		logic [7:0]     rx_last;
		logic           nack;
		logic           ack_sel;
		int unsigned    tpu;
		logic [7:0]     poll_limit;
		bus_levels_t    levels_q[$];
		int unsigned    errors;

		function new();
			ph = ENG_IDLE;
			bit_idx = '0;
			shifter = '0;
			dly = 0;
			polls = '0;
			scl = 1'b1;
			sda = 1'b1;
			rx_last = '0;
			nack = 1'b0;
			ack_sel = 1'b0;
			tpu = 1;
			poll_limit = 8'd250;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [TPU_W-1:0] val);
			if (idx == CFG_TICKS_PER_US) begin
				tpu = val;
			end else if (idx == CFG_ACK_POLL_LIMIT) begin
				poll_limit = val[7:0];
			end
		endfunction

		function bit busy();
			return ph != ENG_IDLE;
		endfunction

		// the tick at hand samples sda for the ack
		function bit polling();
			return ph == ACK_POLL && dly <= 1;
		endfunction

		function int pending();
			return levels_q.size();
		endfunction

		// n microseconds of bus delay, saturated to the counter width
		function void load_wait(int unsigned n, eng_phase_e nxt);
			longint unsigned d;
			longint unsigned dmax;
			dmax = (longint'(1) << DLY_W) - 1;
			d = longint'(n) * tpu;
			dly = (d > dmax) ? int'(dmax) : int'(d);
			ph = nxt;
		endfunction

		function void shift_out();
			sda = shifter[7];
			shifter = {shifter[6:0], 1'b0};
			load_wait(2, WR_SETUP);
		endfunction

		function void begin_stop();
			scl = 1'b1;
			sda = 1'b0;
			load_wait(4, STOP_HOLD);
		endfunction

		// advance one tick and queue the levels it leaves on the bus
		function void take_tick(req_t r);
			bus_levels_t lv;
			logic done_now;
			done_now = 1'b0;
			if (ph == ENG_IDLE) begin
				case (r.op)
					CMD_START: begin
						sda = 1'b1;
						scl = 1'b1;
						load_wait(4, START_HOLD);
					end
					CMD_STOP: begin_stop();
					CMD_WRITE: begin
						nack = 1'b0;
						shifter = r.tx_byte;
						bit_idx = '0;
						shift_out();
					end
					CMD_READ: begin
						ack_sel = r.send_ack;
						shifter = '0;
						bit_idx = '0;
						sda = 1'b1;
						scl = 1'b1;
						load_wait(2, RD_HIGH);
					end
					default: ;
				endcase
			end else if (dly > 1) begin
				dly--;
			end else begin
				case (ph)
					START_HOLD: begin
						sda = 1'b0;
						load_wait(4, START_LOW);
					end
					START_LOW: begin
						scl = 1'b0;
						ph = ENG_IDLE;
						done_now = 1'b1;
					end
					STOP_HOLD: begin
						sda = 1'b1;
						load_wait(4, STOP_RELEASE);
					end
					STOP_RELEASE: begin
						ph = ENG_IDLE;
						done_now = 1'b1;
					end
					WR_SETUP: begin
						scl = 1'b1;
						load_wait(2, WR_HIGH);
					end
					WR_HIGH: begin
						scl = 1'b0;
						load_wait(2, WR_LOW);
					end
					WR_LOW: begin
						if (bit_idx == 3'd7) begin
							sda = 1'b1;
							load_wait(1, ACK_SETUP);
						end else begin
							bit_idx++;
							shift_out();
						end
					end
					ACK_SETUP: begin
						scl = 1'b1;
						polls = '0;
						load_wait(1, ACK_POLL);
					end
					ACK_POLL: begin
						dly = 0;
						if (!r.sda_in) begin
							scl = 1'b0;
							nack = 1'b0;
							ph = ENG_IDLE;
							done_now = 1'b1;
						end else begin
							if (polls != 8'hFF) polls++;
							if (polls > poll_limit) begin
								nack = 1'b1;
								begin_stop();
							end
						end
					end
					RD_HIGH: begin
						shifter = {shifter[6:0], r.sda_in};
						scl = 1'b0;
						load_wait(1, RD_LOW);
					end
					RD_LOW: begin
						if (bit_idx < 3'd7) begin
							bit_idx++;
							scl = 1'b1;
							load_wait(2, RD_HIGH);
						end else begin
							rx_last = shifter;
							sda = !ack_sel;
							load_wait(2, MACK_SETUP);
						end
					end
					MACK_SETUP: begin
						scl = 1'b1;
						load_wait(2, MACK_HIGH);
					end
					MACK_HIGH: begin
						scl = 1'b0;
						load_wait(2, MACK_LOW);
					end
					MACK_LOW: begin
						if (ack_sel) sda = 1'b1;
						ph = ENG_IDLE;
						done_now = 1'b1;
					end
					default: ph = ENG_IDLE;
				endcase
			end
			lv.scl = scl;
			lv.sda = sda;
			lv.busy = (ph != ENG_IDLE);
			lv.done = done_now;
			lv.rx = rx_last;
			lv.err = nack;
			levels_q.push_back(lv);
		endfunction

		function void cmp(string name, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				errors++;
				if (errors <= ERR_PRINT)
					$display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
			end
		endfunction

		function void check_levels(logic [STREAM_W-1:0] d);
			bus_levels_t exp_lv;
			if (levels_q.size() == 0) begin
				errors++;
				if (errors <= ERR_PRINT)
					$display("%0t: result with none expected, expected nothing actual %h",
						$time, d);
				return;
			end
			exp_lv = levels_q.pop_front();
			cmp("scl_out", exp_lv.scl, d[0]);
			cmp("sda_out", exp_lv.sda, d[1]);
			cmp("busy_res", exp_lv.busy, d[2]);
			cmp("done_res", exp_lv.done, d[3]);
			cmp("rx_byte", exp_lv.rx, d[11:4]);
			cmp("ack_error", exp_lv.err, d[12]);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [STREAM_W-1:0]    s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [STREAM_W-1:0]    m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [TPU_W-1:0]       cfg_data;

	i2c_engine_shadow shadow;
	bit               throttle;
	int unsigned      ticks_sent;
	int unsigned      cycles;

	i2c_master_byte_engine_core #(
		.DELAY_COUNTER_WIDTH(DLY_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_i2c_master_byte_engine_core: FAIL");
			$finish;
		end
	end

	// receiver with random stall bursts
	initial begin : result_sink
		int unsigned stall;
		stall = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!throttle) stall = 0;
			if (stall == 0 && throttle && $urandom_range(0, 9) == 0)
				stall = $urandom_range(1, 19);
			if (stall != 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) shadow.check_levels(m_tdata);
	end

	task automatic send_tick(req_t r);
		int unsigned gap;
		gap = (throttle && $urandom_range(0, 9) == 0) ? $urandom_range(1, 19) : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, r.sda_in, r.send_ack, r.tx_byte, r.op};
		do @(posedge clk); while (!s_tready);
		shadow.take_tick(r);
		ticks_sent++;
	endtask

	task automatic src_quiet();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		src_quiet();
		while (shadow.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [TPU_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		shadow.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// upper bits of the poll limit write are junk the block drops
	task automatic set_regs(int unsigned tpu, logic [7:0] lim);
		wait_drained();
		write_cfg(CFG_TICKS_PER_US, TPU_W'(tpu));
		write_cfg(CFG_ACK_POLL_LIMIT, {5'($urandom), lim});
	endtask

	// issue one command, then tick until the engine is idle again;
	// nack_polls failed polls come before the ack, noisy adds ignored commands
	task automatic run_cmd(logic [2:0] cmd, logic [7:0] tx, logic ack, int sda_mode,
			int unsigned nack_polls, bit noisy);
		req_t        r;
		int unsigned polled;
		polled = 0;
		r.op = cmd;
		r.tx_byte = tx;
		r.send_ack = ack;
		r.sda_in = (sda_mode == SDA_RAND) ? 1'($urandom) : (sda_mode == SDA_HIGH);
		send_tick(r);
		while (shadow.busy()) begin
			r.op = (noisy && $urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : CMD_NONE;
			r.tx_byte = 8'($urandom);
			r.send_ack = 1'($urandom);
			if (shadow.polling()) begin
				r.sda_in = (polled < nack_polls);
				polled++;
			end else begin
				r.sda_in = (sda_mode == SDA_RAND) ? 1'($urandom) : (sda_mode == SDA_HIGH);
			end
			send_tick(r);
		end
	endtask

	task automatic random_cmd();
		int unsigned pick;
		int unsigned polls;
		logic [2:0]  cmd;
		pick = $urandom_range(0, 99);
		if (pick < 15) cmd = CMD_NONE;
		else if (pick < 20) cmd = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
		else if (pick < 35) cmd = CMD_START;
		else if (pick < 50) cmd = CMD_STOP;
		else if (pick < 80) cmd = CMD_WRITE;
		else cmd = CMD_READ;
		polls = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 3);
		run_cmd(cmd, 8'($urandom), 1'($urandom), SDA_RAND, polls, 1'b1);
	endtask

	initial begin : stimulus
		int unsigned tpu_set[N_SETS];
		int unsigned lim_set[N_SETS];
		int unsigned phase_start;
		bit          paused;
		tpu_set = '{1, 0, 2, 3, 1, 0};
		lim_set = '{250, 0, 3, 255, 1, 40};
		shadow = new();
		throttle = 1'b1;
		ticks_sent = 0;
		cycles = 0;
		paused = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset settings first
		run_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND, 0, 1'b0);
		run_cmd(CMD_WRITE, 8'h00, 1'b0, SDA_RAND, 0, 1'b0);
		run_cmd(CMD_WRITE, 8'hFF, 1'b1, SDA_RAND, 2, 1'b0);
		run_cmd(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 0, 1'b0);
		run_cmd(CMD_READ, 8'hFF, 1'b0, SDA_LOW, 0, 1'b0);
		run_cmd(CMD_WRITE, 8'h5A, 1'b0, SDA_RAND, 1, 1'b1);
		run_cmd(CMD_STOP, 8'hA5, 1'b1, SDA_RAND, 0, 1'b0);
		for (int c = CMD_BAD_LO; c <= CMD_BAD_HI; c++)
			run_cmd(3'(c), 8'($urandom), 1'($urandom), SDA_RAND, 0, 1'b0);
		run_cmd(CMD_NONE, 8'h00, 1'b0, SDA_LOW, 0, 1'b0);
		// no ack within the limit: error flag and stop sequence
		set_regs(1, 8'd2);
		run_cmd(CMD_WRITE, 8'hC3, 1'b0, SDA_RAND, 10, 1'b0);
		run_cmd(CMD_READ, 8'h3C, 1'b1, SDA_RAND, 0, 1'b0);
		// limit 255 never times out, poll count sticks at its top
		set_regs(0, 8'd255);
		run_cmd(CMD_WRITE, 8'h81, 1'b0, SDA_RAND, 260, 1'b0);
		// limit 0: the first failed poll times out
		set_regs(1, 8'd0);
		run_cmd(CMD_WRITE, 8'h7E, 1'b0, SDA_RAND, 1, 1'b0);
		run_cmd(CMD_WRITE, 8'h18, 1'b0, SDA_RAND, 0, 1'b0);

		for (int p = 0; p < N_SETS; p++) begin
			set_regs(tpu_set[p], 8'(lim_set[p]));
			phase_start = ticks_sent;
			while (ticks_sent - phase_start < PHASE_TICKS) begin
				random_cmd();
				if (p == 2 && !paused && ticks_sent - phase_start > PHASE_TICKS / 2) begin
					wait_drained();
					paused = 1'b1;
				end
			end
		end

		// last part: reset settings, back to back with no stalls
		throttle = 1'b0;
		set_regs(1, 8'd250);
		run_cmd(CMD_WRITE, 8'hA6, 1'b0, SDA_RAND, 1, 1'b0);
		run_cmd(CMD_READ, 8'h00, 1'b1, SDA_RAND, 0, 1'b0);

		wait_drained();
		if (shadow.errors == 0 && shadow.pending() == 0) begin
			$display("tb_i2c_master_byte_engine_core: PASS");
		end else begin
			$display("tb_i2c_master_byte_engine_core: FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/i2c_mbe_pkg.sv
sv/i2c_mbe_front.sv
sv/i2c_mbe_back.sv
sv/i2c_master_byte_engine_core.sv
sv/i2c_mbe_checker.sv
tb/tb_i2c_master_byte_engine_core.sv
